>>> sv/i2cms_pkg.sv
// Shared types, field widths and codes of the I2C master bit sequencer.
package i2cms_pkg;

  localparam int unsigned DEF_TICK_COUNT_WIDTH = 16;
  localparam int unsigned QPT_WIDTH            = 16;
  localparam logic [QPT_WIDTH-1:0] QPT_RESET   = 16'd250;

  localparam int unsigned CMD_WIDTH  = 3;
  localparam int unsigned STEP_WIDTH = 3;

  localparam logic [CMD_WIDTH-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_STOP    = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_RESTART = 3'd5;

  localparam logic [STEP_WIDTH-1:0] ST_IDLE    = 3'd0;
  localparam logic [STEP_WIDTH-1:0] ST_START   = 3'd1;
  localparam logic [STEP_WIDTH-1:0] ST_TXBIT   = 3'd2;
  localparam logic [STEP_WIDTH-1:0] ST_ACKIN   = 3'd3;
  localparam logic [STEP_WIDTH-1:0] ST_RXBIT   = 3'd4;
  localparam logic [STEP_WIDTH-1:0] ST_ACKOUT  = 3'd5;
  localparam logic [STEP_WIDTH-1:0] ST_STOP    = 3'd6;
  localparam logic [STEP_WIDTH-1:0] ST_RESTART = 3'd7;

  typedef struct packed {
    logic [CMD_WIDTH-1:0] command;
    logic [6:0]           target_addr;
    logic                 read_not_write;
    logic [7:0]           tx_byte;
    logic                 master_ack;
    logic                 scl_in;
    logic                 sda_in;
  } i2cms_item_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_received;
    logic [7:0] rx_byte;
    logic       command_done;
    logic       busy_res;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } i2cms_result_t;

endpackage

>>> sv/i2cms_core.sv
// Bit sequencer state and the per-tick next-state and result logic.
module i2cms_core
  import i2cms_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = DEF_TICK_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  i2cms_item_t          item,
  input  logic [QPT_WIDTH-1:0] qp_ticks,
  output i2cms_result_t        result
);

  localparam int unsigned CW = ((TICK_COUNT_WIDTH > QPT_WIDTH) ? TICK_COUNT_WIDTH : QPT_WIDTH) + 1;
  localparam logic [CW-1:0] CAP = {{(CW-1){1'b0}}, 1'b1} << TICK_COUNT_WIDTH;

  logic [STEP_WIDTH-1:0]       step, step_next;
  logic [1:0]                  quarter, quarter_next;
  logic [3:0]                  bit_index, bit_index_next;
  logic [7:0]                  tx_shift, tx_shift_next;
  logic [7:0]                  rx_shift, rx_shift_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic                        scl_low, scl_low_next;
  logic                        sda_low, sda_low_next;
  logic                        ack_flag, ack_flag_next;
  logic                        ack_to_send, ack_to_send_next;

  logic [CMD_WIDTH-1:0] cmd;
  logic [CW-1:0]        tick_inc;
  logic [CW-1:0]        qp_raw;
  logic [CW-1:0]        qp_eff;
  logic [1:0]           last_q;
  logic [3:0]           bit_inc;
  logic                 enter;
  logic                 rejected;
  logic                 done;

  always_comb begin
    qp_raw = (qp_ticks == '0) ? CW'(1) : CW'(qp_ticks);
    qp_eff = (qp_raw > CAP) ? CAP : qp_raw;
    tick_inc = CW'(tick_count) + CW'(1);
    bit_inc = bit_index + 4'd1;
    cmd = (item.command > CMD_RESTART) ? CMD_NONE : item.command;
    case (step)
      ST_START, ST_STOP: last_q = 2'd2;
      ST_RESTART:        last_q = 2'd1;
      default:           last_q = 2'd3;
    endcase

    step_next        = step;
    quarter_next     = quarter;
    bit_index_next   = bit_index;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    tick_count_next  = tick_count;
    scl_low_next     = scl_low;
    sda_low_next     = sda_low;
    ack_flag_next    = ack_flag;
    ack_to_send_next = ack_to_send;
    enter            = 1'b0;
    rejected         = 1'b0;
    done             = 1'b0;

    if (step != ST_IDLE) begin
      rejected = (cmd != CMD_NONE);
      if (tick_inc < qp_eff) begin
        tick_count_next = tick_inc[TICK_COUNT_WIDTH-1:0];
      end else if (quarter == 2'd1 && step == ST_RXBIT && !item.scl_in) begin
        // The slave is stretching the clock: hold until SCL is seen high.
        tick_count_next = tick_count;
      end else begin
        if (quarter == 2'd1) begin
          if (step == ST_RXBIT) begin
            tx_shift_next = {tx_shift[6:0], item.sda_in};
          end else if (step == ST_ACKIN) begin
            ack_flag_next = item.sda_in;
          end
        end
        tick_count_next = '0;
        if (quarter < last_q) begin
          quarter_next = quarter + 2'd1;
          enter = 1'b1;
        end else begin
          quarter_next = 2'd0;
          case (step)
            ST_START: begin
              step_next = ST_TXBIT;
              bit_index_next = 4'd0;
              enter = 1'b1;
            end
            ST_TXBIT: begin
              tx_shift_next = {tx_shift[6:0], 1'b0};
              bit_index_next = bit_inc;
              if (bit_inc[3]) begin
                step_next = ST_ACKIN;
                bit_index_next = 4'd0;
              end
              enter = 1'b1;
            end
            ST_RXBIT: begin
              bit_index_next = bit_inc;
              if (bit_inc[3]) begin
                step_next = ST_ACKOUT;
                bit_index_next = 4'd0;
              end
              enter = 1'b1;
            end
            ST_ACKOUT: begin
              rx_shift_next = tx_shift;
              step_next = ST_IDLE;
              done = 1'b1;
            end
            default: begin
              step_next = ST_IDLE;
              done = 1'b1;
            end
          endcase
        end
      end
    end else if (cmd != CMD_NONE) begin
      quarter_next = 2'd0;
      tick_count_next = '0;
      bit_index_next = 4'd0;
      enter = 1'b1;
      case (cmd)
        CMD_START: begin
          tx_shift_next = {item.target_addr, item.read_not_write};
          step_next = ST_START;
        end
        CMD_WRITE: begin
          tx_shift_next = item.tx_byte;
          step_next = ST_TXBIT;
        end
        CMD_READ: begin
          tx_shift_next = 8'd0;
          ack_to_send_next = item.master_ack;
          step_next = ST_RXBIT;
        end
        CMD_STOP: step_next = ST_STOP;
        default:  step_next = ST_RESTART;
      endcase
    end

    if (enter) begin
      case (step_next)
        ST_START: begin
          if (quarter_next == 2'd0) sda_low_next = 1'b1;
          if (quarter_next == 2'd2) scl_low_next = 1'b1;
        end
        ST_TXBIT, ST_ACKIN, ST_RXBIT, ST_ACKOUT: begin
          if (quarter_next == 2'd0) begin
            scl_low_next = 1'b1;
            if (step_next == ST_TXBIT) begin
              sda_low_next = ~tx_shift_next[7];
            end else if (step_next == ST_ACKOUT) begin
              sda_low_next = ack_to_send_next;
            end else begin
              sda_low_next = 1'b0;
            end
          end
          if (quarter_next == 2'd1) scl_low_next = 1'b0;
          if (quarter_next == 2'd3) scl_low_next = 1'b1;
        end
        ST_STOP: begin
          if (quarter_next == 2'd0) sda_low_next = 1'b1;
          if (quarter_next == 2'd1) scl_low_next = 1'b0;
          if (quarter_next == 2'd2) sda_low_next = 1'b0;
        end
        ST_RESTART: begin
          if (quarter_next == 2'd0) sda_low_next = 1'b0;
          if (quarter_next == 2'd1) scl_low_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    result.scl_drive_low = scl_low_next;
    result.sda_drive_low = sda_low_next;
    result.busy_res      = (step_next != ST_IDLE);
    result.command_done  = done;
    result.rx_byte       = rx_shift_next;
    result.ack_received  = ack_flag_next;
    result.rejected      = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_IDLE;
      quarter     <= 2'd0;
      bit_index   <= 4'd0;
      tx_shift    <= 8'd0;
      rx_shift    <= 8'd0;
      tick_count  <= '0;
      scl_low     <= 1'b0;
      sda_low     <= 1'b0;
      ack_flag    <= 1'b0;
      ack_to_send <= 1'b0;
    end else if (advance) begin
      step        <= step_next;
      quarter     <= quarter_next;
      bit_index   <= bit_index_next;
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      tick_count  <= tick_count_next;
      scl_low     <= scl_low_next;
      sda_low     <= sda_low_next;
      ack_flag    <= ack_flag_next;
      ack_to_send <= ack_to_send_next;
    end
  end

endmodule

>>> sv/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: input and result registers around the core.
//
//  Channel  Signals                         Contents
//  s        s_tvalid s_tready s_tdata s_tuser  one base-clock tick with pins and command
//  m        m_tvalid m_tready m_tdata          pin drives and status after that tick
//  cfg      cfg_wen cfg_wdata                  quarter period in base-clock ticks
//
// Every input transfer yields exactly one result transfer, through the input register and then the result register.
// One transfer per cycle is sustained while m does not stall; the core state updates once per tick.
// Synchronous reset returns the bus to idle, both lines released, divider at 250.
// A stall on m holds the result register and, through it, the input register.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = DEF_TICK_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // target_addr[6:0], read_not_write[7], tx_byte[15:8], master_ack[16],
  // scl_in[17], sda_in[18], zero padding[23:19]
  input  logic [23:0] s_tdata,
  // command[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_drive_low[0], sda_drive_low[1], busy_res[2], command_done[3],
  // rx_byte[11:4], ack_received[12], rejected[13], zero padding[15:14]
  output logic [15:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  logic                 in_valid;
  i2cms_item_t          in_item;
  logic                 out_valid;
  i2cms_result_t        out_res;
  i2cms_result_t        core_res;
  logic [QPT_WIDTH-1:0] qp_ticks;
  logic                 advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      qp_ticks <= QPT_RESET;
    end else if (cfg_wen) begin
      qp_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command        <= s_tuser;
      in_item.target_addr    <= s_tdata[6:0];
      in_item.read_not_write <= s_tdata[7];
      in_item.tx_byte        <= s_tdata[15:8];
      in_item.master_ack     <= s_tdata[16];
      in_item.scl_in         <= s_tdata[17];
      in_item.sda_in         <= s_tdata[18];
    end
  end

  i2cms_core #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_item),
    .qp_ticks (qp_ticks),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.command_done && out_res.busy_res))
    else $error("command_done reported while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.rejected) |-> (out_res.busy_res || out_res.command_done))
    else $error("command rejected while the sequencer was idle");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |=> out_valid)
    else $error("held input tick did not reach the result register");

endmodule

>>> tb/sv/i2c_master_bit_sequencer_test.sv
// Self-checking testbench for the I2C master bit sequencer, driven tick by tick.
module i2c_master_bit_sequencer_test;
  import i2cms_pkg::*;

  localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = CMD_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  i2c_master_bit_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2cms_item_t   tick_q[$];
  i2cms_result_t bus_status_q[$];
  i2cms_item_t   offered_tick;
  int unsigned   fault_count = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  int unsigned   gen_divider = 250;
  logic          long_hold_req = 1'b0;
  logic          hold_taken = 1'b0;
  int unsigned   hold_left = 0;

  // Expected bus state, kept alongside the block.
  logic [15:0]           bus_divider = QPT_RESET;
  logic [STEP_WIDTH-1:0] seq_step = ST_IDLE;
  logic [1:0]            seq_quarter = '0;
  logic [3:0]            seq_bit = '0;
  logic [7:0]            shift_reg = '0;
  logic [7:0]            rx_hold = '0;
  logic [15:0]           quarter_ticks = '0;
  logic                  scl_low = 1'b0;
  logic                  sda_low = 1'b0;
  logic                  ack_seen = 1'b0;
  logic                  ack_plan = 1'b0;

  function automatic logic [1:0] last_quarter_of(logic [STEP_WIDTH-1:0] step);
    if (step == ST_START || step == ST_STOP) return 2'd2;
    if (step == ST_RESTART) return 2'd1;
    return 2'd3;
  endfunction

  function automatic void drive_quarter_pins();
    case (seq_step)
      ST_START: begin
        if (seq_quarter == 2'd0) sda_low = 1'b1;
        if (seq_quarter == 2'd2) scl_low = 1'b1;
      end
      ST_TXBIT, ST_ACKIN, ST_RXBIT, ST_ACKOUT: begin
        if (seq_quarter == 2'd0) begin
          scl_low = 1'b1;
          if (seq_step == ST_TXBIT) sda_low = ~shift_reg[7];
          else if (seq_step == ST_ACKOUT) sda_low = ack_plan;
          else sda_low = 1'b0;
        end
        if (seq_quarter == 2'd1) scl_low = 1'b0;
        if (seq_quarter == 2'd3) scl_low = 1'b1;
      end
      ST_STOP: begin
        if (seq_quarter == 2'd0) sda_low = 1'b1;
        if (seq_quarter == 2'd1) scl_low = 1'b0;
        if (seq_quarter == 2'd2) sda_low = 1'b0;
      end
      ST_RESTART: begin
        if (seq_quarter == 2'd0) sda_low = 1'b0;
        if (seq_quarter == 2'd1) scl_low = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Advances a running command by one tick; returns 1 when the command completes.
  function automatic logic quarter_timer_step(logic scl_pin, logic sda_pin);
    int unsigned span;
    span = (bus_divider == 16'd0) ? 1 : bus_divider;
    if (quarter_ticks + 1 < span) begin
      quarter_ticks = quarter_ticks + 16'd1;
      return 1'b0;
    end
    if (seq_quarter == 2'd1) begin
      if (seq_step == ST_RXBIT) begin
        if (!scl_pin) return 1'b0;
        shift_reg = {shift_reg[6:0], sda_pin};
      end else if (seq_step == ST_ACKIN) begin
        ack_seen = sda_pin;
      end
    end
    quarter_ticks = '0;
    if (seq_quarter < last_quarter_of(seq_step)) begin
      seq_quarter = seq_quarter + 2'd1;
      drive_quarter_pins();
      return 1'b0;
    end
    seq_quarter = '0;
    case (seq_step)
      ST_START: begin
        seq_step = ST_TXBIT;
        seq_bit = '0;
      end
      ST_TXBIT: begin
        shift_reg = shift_reg << 1;
        seq_bit = seq_bit + 4'd1;
        if (seq_bit >= 4'd8) begin
          seq_step = ST_ACKIN;
          seq_bit = '0;
        end
      end
      ST_RXBIT: begin
        seq_bit = seq_bit + 4'd1;
        if (seq_bit >= 4'd8) begin
          seq_step = ST_ACKOUT;
          seq_bit = '0;
        end
      end
      ST_ACKOUT: begin
        rx_hold = shift_reg;
        seq_step = ST_IDLE;
        return 1'b1;
      end
      default: begin
        seq_step = ST_IDLE;
        return 1'b1;
      end
    endcase
    drive_quarter_pins();
    return 1'b0;
  endfunction

  function automatic i2cms_result_t predict_bus_tick(i2cms_item_t t);
    logic [CMD_WIDTH-1:0] op;
    logic                 done;
    logic                 dropped;
    i2cms_result_t        r;
    op = (t.command > CMD_RESTART) ? CMD_NONE : t.command;
    done = 1'b0;
    dropped = 1'b0;
    if (seq_step != ST_IDLE) begin
      dropped = (op != CMD_NONE);
      done = quarter_timer_step(t.scl_in, t.sda_in);
    end else if (op != CMD_NONE) begin
      seq_quarter = '0;
      quarter_ticks = '0;
      seq_bit = '0;
      case (op)
        CMD_START: begin
          shift_reg = {t.target_addr, t.read_not_write};
          seq_step = ST_START;
        end
        CMD_WRITE: begin
          shift_reg = t.tx_byte;
          seq_step = ST_TXBIT;
        end
        CMD_READ: begin
          shift_reg = '0;
          ack_plan = t.master_ack;
          seq_step = ST_RXBIT;
        end
        CMD_STOP: seq_step = ST_STOP;
        default: seq_step = ST_RESTART;
      endcase
      drive_quarter_pins();
    end
    r.scl_drive_low = scl_low;
    r.sda_drive_low = sda_low;
    r.busy_res = (seq_step != ST_IDLE);
    r.command_done = done;
    r.rx_byte = rx_hold;
    r.ack_received = ack_seen;
    r.rejected = dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) bus_status_q.push_back(predict_bus_tick(offered_tick));
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_tick = tick_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= offered_tick.command;
          s_tdata <= {5'b0, offered_tick.sda_in, offered_tick.scl_in, offered_tick.master_ack,
                      offered_tick.tx_byte, offered_tick.read_not_write,
                      offered_tick.target_addr};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_left <= 400;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : result_monitor
    i2cms_result_t seen;
    i2cms_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = i2cms_result_t'(m_tdata[13:0]);
        if (bus_status_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("result transfer %h at %0t with nothing expected",
                                          m_tdata, $time);
        end else begin
          want = bus_status_q.pop_front();
          if (seen.scl_drive_low !== want.scl_drive_low ||
              seen.sda_drive_low !== want.sda_drive_low ||
              seen.busy_res !== want.busy_res || seen.command_done !== want.command_done ||
              seen.rx_byte !== want.rx_byte || seen.ack_received !== want.ack_received ||
              seen.rejected !== want.rejected) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch at %0t: expected scl %0b sda %0b busy %0b done %0b rx %h ack %0b rej %0b",
                       $time, want.scl_drive_low, want.sda_drive_low, want.busy_res,
                       want.command_done, want.rx_byte, want.ack_received, want.rejected);
              $display("  received             scl %0b sda %0b busy %0b done %0b rx %h ack %0b rej %0b",
                       seen.scl_drive_low, seen.sda_drive_low, seen.busy_res,
                       seen.command_done, seen.rx_byte, seen.ack_received, seen.rejected);
            end
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic i2cms_item_t random_tick();
    i2cms_item_t t;
    logic [31:0] rnd;
    rnd = $urandom;
    t.command = CMD_NONE;
    t.target_addr = rnd[6:0];
    t.read_not_write = rnd[7];
    t.tx_byte = rnd[15:8];
    t.master_ack = rnd[16];
    t.scl_in = rnd[17];
    t.sda_in = rnd[18];
    return t;
  endfunction

  // Queues a command tick and the ticks it keeps the bus busy, then a short idle gap.
  task automatic issue_command(i2cms_item_t first, int sda_level);
    int unsigned unit;
    int unsigned quarters;
    int unsigned k;
    int unsigned stretch;
    i2cms_item_t t;
    i2cms_item_t held;
    unit = (gen_divider == 0) ? 1 : gen_divider;
    case (first.command)
      CMD_START: quarters = 39;
      CMD_WRITE, CMD_READ: quarters = 36;
      CMD_STOP: quarters = 3;
      CMD_RESTART: quarters = 2;
      default: quarters = 0;
    endcase
    if (sda_level >= 0) first.sda_in = sda_level[0];
    tick_q.push_back(first);
    for (k = 1; k <= quarters * unit; k++) begin
      t = random_tick();
      if (sda_level >= 0) t.sda_in = sda_level[0];
      if ($urandom_range(99) < 8) t.command = 3'($urandom_range(7));
      if (first.command == CMD_READ && k < 32 * unit && k % (4 * unit) == 2 * unit) begin
        stretch = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
        repeat (stretch) begin
          held = random_tick();
          held.scl_in = 1'b0;
          tick_q.push_back(held);
        end
        t.scl_in = 1'b1;
      end
      tick_q.push_back(t);
    end
    repeat ($urandom_range(3)) begin
      t = random_tick();
      if ($urandom_range(9) == 0) t.command = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      tick_q.push_back(t);
    end
  endtask

  task automatic send_op(logic [CMD_WIDTH-1:0] op, logic [6:0] addr, logic rnw,
                         logic [7:0] data, logic mack, int sda_level);
    i2cms_item_t t;
    t = random_tick();
    t.command = op;
    t.target_addr = addr;
    t.read_not_write = rnw;
    t.tx_byte = data;
    t.master_ack = mack;
    issue_command(t, sda_level);
  endtask

  task automatic wait_for_drain();
    while (tick_q.size() != 0 || s_tvalid || bus_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_divider(int unsigned value);
    wait_for_drain();
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value[15:0];
    bus_divider = value[15:0];
    gen_divider = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed transactions with random content, the rest stray commands.
  task automatic random_transaction();
    i2cms_item_t t;
    int unsigned chains;
    int unsigned c;
    int unsigned n;
    int unsigned i;
    logic        reading;
    if ($urandom_range(99) < 15) begin
      t = random_tick();
      t.command = 3'($urandom_range(1, 7));
      issue_command(t, -1);
      return;
    end
    chains = ($urandom_range(3) == 0) ? 2 : 1;
    for (c = 0; c < chains; c++) begin
      if (c != 0) begin
        t = random_tick();
        t.command = CMD_RESTART;
        issue_command(t, -1);
      end
      t = random_tick();
      t.command = CMD_START;
      reading = t.read_not_write;
      issue_command(t, -1);
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) begin
        t = random_tick();
        if (reading) begin
          t.command = CMD_READ;
          t.master_ack = (i + 1 < n);
          if ($urandom_range(9) == 0) t.master_ack = ~t.master_ack;
        end else begin
          t.command = CMD_WRITE;
        end
        issue_command(t, -1);
      end
    end
    t = random_tick();
    t.command = CMD_STOP;
    issue_command(t, -1);
  endtask

  initial begin
    #500000;
    $display("i2c_master_bit_sequencer regression: fail");
    $finish;
  end

  initial begin : stimulus
    i2cms_item_t t;
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_op(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, -1);
    t = random_tick();
    t.command = CMD_SPARE_A;
    tick_q.push_back(t);
    t.command = CMD_SPARE_B;
    tick_q.push_back(t);

    set_divider(0);
    send_op(CMD_START, 7'h2A, 1'b0, 8'h00, 1'b0, 0);
    send_op(CMD_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0, 1);
    send_op(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, 1);
    send_op(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, -1);

    // Divider rewritten in the middle of a write byte.
    set_divider(2);
    t = random_tick();
    t.command = CMD_WRITE;
    t.tx_byte = 8'hA5;
    tick_q.push_back(t);
    repeat (10) tick_q.push_back(random_tick());
    set_divider(1);
    repeat (40) tick_q.push_back(random_tick());

    // Longest divider, cut short by a rewrite while the restart release runs.
    set_divider(65535);
    t = random_tick();
    t.command = CMD_RESTART;
    tick_q.push_back(t);
    repeat (10) tick_q.push_back(random_tick());
    set_divider(1);
    repeat (4) tick_q.push_back(random_tick());

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 49;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 49;
        end
        default: begin
          sender_idle_pct = 35;
          receiver_stall_pct = 35;
        end
      endcase
      set_divider($urandom_range(1));
      while (tick_q.size() < 60) random_transaction();
      if (phase == 0) long_hold_req = 1'b1;
    end

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (fault_count == 0 && bus_status_q.size() == 0) begin
      $display("i2c_master_bit_sequencer regression: pass");
    end else begin
      $display("i2c_master_bit_sequencer regression: fail");
    end
    $finish;
  end

endmodule
